// ===== sv/ppde_pkg.sv =====
// Package of shared types and constants for the point pair distance engine.
`default_nettype none
package ppde_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 24;
    localparam int IDX_BITS       = 10;
    localparam int EXTENT_BITS    = 24;
    localparam int DIST_BITS      = 25;
    localparam int CFG_IDX_BITS   = 2;
    localparam int ROOT_BITS      = 32;
    localparam int SUM_BITS       = 64;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WRAP_MODE = 2'd0,
        CFG_EXTENT_X  = 2'd1,
        CFG_EXTENT_Y  = 2'd2,
        CFG_EXTENT_Z  = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_WRAP,
        S_SQUARE,
        S_SUM1,
        S_SUM2,
        S_ROOT,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== sv/ppde_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`default_nettype none
module ppde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire [WIDTH-1:0]          wr_data,
    input  wire                      rd_en,
    input  wire [$clog2(DEPTH)-1:0]  rd_addr_a,
    input  wire [$clog2(DEPTH)-1:0]  rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule
`default_nettype wire

// ===== sv/point_pair_distance_engine.sv =====
// Top level: point store in RAM and a multi-cycle distance and square root datapath.
// A write leaves the input ready, so a new item can be taken on the next cycle.
// A query runs through the fetch, wrap, square, two sum, 32-step square root and done
// states; input is ready again as the result shows, and one query is in flight at a time.
// Equal indices skip to the done state and show zero. A result that is still waiting adds
// its wait. Synchronous active-low reset clears the sequencer, output valid and wrap mode.
`default_nettype none
module point_pair_distance_engine #(
    parameter int MAX_POINTS = ppde_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = ppde_pkg::COORD_BITS_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [ppde_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire [ppde_pkg::EXTENT_BITS-1:0]    cfg_data,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire                                s_opcode,
    input  wire [ppde_pkg::IDX_BITS-1:0]       s_first_index,
    input  wire [ppde_pkg::IDX_BITS-1:0]       s_second_index,
    input  wire signed [COORD_BITS-1:0]        s_coord_x,
    input  wire signed [COORD_BITS-1:0]        s_coord_y,
    input  wire signed [COORD_BITS-1:0]        s_coord_z,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [ppde_pkg::DIST_BITS-1:0]     m_distance
);
    import ppde_pkg::*;

    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int ENTRY_W = 3 * COORD_BITS;
    localparam int TW = ((COORD_BITS > EXTENT_BITS) ? COORD_BITS : EXTENT_BITS) + 2;
    localparam int REM_W = ROOT_BITS + 3;
    localparam int CNT_W = $clog2(ROOT_BITS);

    state_t state_reg, state_next;
    logic wrap_reg, wrap_next;
    logic [2:0][EXTENT_BITS-1:0] ext_reg, ext_next;
    logic ok_i_reg, ok_i_next, ok_j_reg, ok_j_next;
    logic [2:0][COORD_BITS-1:0] d_reg, d_next;
    logic [2:0][TW-1:0] mag_reg, mag_next;
    logic [2:0][SUM_BITS-1:0] sq_reg, sq_next;
    logic [SUM_BITS-1:0] sum_reg, sum_next;
    logic [SUM_BITS-1:0] rad_reg, rad_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [ROOT_BITS-1:0] root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic m_valid_reg, m_valid_next;
    logic [DIST_BITS-1:0] m_dist_reg, m_dist_next;

    logic s_xfer, wr_en, rd_en, out_free;
    logic [ENTRY_W-1:0] rd_a, rd_b;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_xfer    = s_valid && s_ready;
    assign wr_en     = s_xfer && (s_opcode == OP_WRITE) && (32'(s_first_index) < MAX_POINTS);
    assign rd_en     = s_xfer && (s_opcode == OP_QUERY);
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_distance = m_dist_reg;

    ppde_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (ADDR_W'(s_first_index)),
        .wr_data   ({s_coord_z, s_coord_y, s_coord_x}),
        .rd_en     (rd_en),
        .rd_addr_a (ADDR_W'(s_first_index)),
        .rd_addr_b (ADDR_W'(s_second_index)),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    always_comb begin
        logic signed [COORD_BITS-1:0] ca, cb;
        logic signed [COORD_BITS:0] diff;
        logic signed [TW-1:0] w, ds, term;
        logic [SUM_BITS-1:0] m64;
        logic [SUM_BITS:0] s;
        logic [REM_W-1:0] rem_sh, test;

        ca     = '0;
        cb     = '0;
        diff   = '0;
        w      = '0;
        ds     = '0;
        term   = '0;
        m64    = '0;
        s      = '0;
        rem_sh = '0;
        test   = '0;

        state_next   = state_reg;
        wrap_next    = wrap_reg;
        ext_next     = ext_reg;
        ok_i_next    = ok_i_reg;
        ok_j_next    = ok_j_reg;
        d_next       = d_reg;
        mag_next     = mag_reg;
        sq_next      = sq_reg;
        sum_next     = sum_reg;
        rad_next     = rad_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_dist_next  = m_dist_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                CFG_WRAP_MODE: wrap_next  = cfg_data[0];
                CFG_EXTENT_X:  ext_next[0] = cfg_data;
                CFG_EXTENT_Y:  ext_next[1] = cfg_data;
                CFG_EXTENT_Z:  ext_next[2] = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_xfer && s_opcode == OP_QUERY) begin
                    ok_i_next = (32'(s_first_index) < MAX_POINTS);
                    ok_j_next = (32'(s_second_index) < MAX_POINTS);
                    if (s_first_index == s_second_index) begin
                        root_next  = '0;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                for (int k = 0; k < 3; k++) begin
                    ca = ok_i_reg ? rd_a[k*COORD_BITS +: COORD_BITS] : '0;
                    cb = ok_j_reg ? rd_b[k*COORD_BITS +: COORD_BITS] : '0;
                    diff = (COORD_BITS+1)'(ca) - (COORD_BITS+1)'(cb);
                    d_next[k] = (diff < 0) ? COORD_BITS'(-diff) : COORD_BITS'(diff);
                end
                state_next = S_WRAP;
            end
            S_WRAP: begin
                for (int k = 0; k < 3; k++) begin
                    ds = TW'(d_reg[k]);
                    w = TW'(ext_reg[k]) - ds;
                    term = (wrap_reg && (w < ds)) ? w : ds;
                    mag_next[k] = (term < 0) ? TW'(-term) : TW'(term);
                end
                state_next = S_SQUARE;
            end
            S_SQUARE: begin
                for (int k = 0; k < 3; k++) begin
                    m64 = SUM_BITS'(mag_reg[k]);
                    sq_next[k] = (|m64[63:32]) ? '1
                                 : SUM_BITS'(m64[31:0]) * SUM_BITS'(m64[31:0]);
                end
                state_next = S_SUM1;
            end
            S_SUM1: begin
                s = {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]};
                sum_next = s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
                state_next = S_SUM2;
            end
            S_SUM2: begin
                s = {1'b0, sum_reg} + {1'b0, sq_reg[2]};
                rad_next   = s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = S_ROOT;
            end
            S_ROOT: begin
                rem_sh = {rem_reg[REM_W-3:0], rad_reg[SUM_BITS-1 -: 2]};
                test   = REM_W'({root_reg, 2'b01});
                if (rem_sh >= test) begin
                    rem_next  = rem_sh - test;
                    root_next = {root_reg[ROOT_BITS-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[ROOT_BITS-2:0], 1'b0};
                end
                rad_next = {rad_reg[SUM_BITS-3:0], 2'b00};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_BITS - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_dist_next  = (|root_reg[ROOT_BITS-1:DIST_BITS]) ? '1
                                   : root_reg[DIST_BITS-1:0];
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            wrap_reg    <= 1'b0;
            ext_reg     <= {3{{EXTENT_BITS{1'b1}}}};
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wrap_reg    <= wrap_next;
            ext_reg     <= ext_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ok_i_reg   <= ok_i_next;
        ok_j_reg   <= ok_j_next;
        d_reg      <= d_next;
        mag_reg    <= mag_next;
        sq_reg     <= sq_next;
        sum_reg    <= sum_next;
        rad_reg    <= rad_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        cnt_reg    <= cnt_next;
        m_dist_reg <= m_dist_next;
    end

`ifndef NO_ASSERTIONS
    a_query_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == OP_QUERY) |=> !s_ready)
        else $error("Input taken while a query was in flight.");

    a_write_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == OP_WRITE) |=> s_ready)
        else $error("A write held the input side for more than one cycle.");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_DONE))
        else $error("Result presented outside of the completion step.");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the point pair distance engine with a built-in distance predictor.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ppde_pkg::*;

    typedef struct {
        opcode_t            op;
        logic [9:0]         fi;
        logic [9:0]         si;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
    } point_op_t;

    localparam int CYCLE_LIMIT = 600000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [EXTENT_BITS-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_opcode = 1'b0;
    logic [IDX_BITS-1:0] s_first_index = '0;
    logic [IDX_BITS-1:0] s_second_index = '0;
    logic signed [23:0] s_coord_x = '0;
    logic signed [23:0] s_coord_y = '0;
    logic signed [23:0] s_coord_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [DIST_BITS-1:0] m_distance;

    point_pair_distance_engine dut (.*);

    point_op_t          op_queue[$];
    logic [24:0]        dist_expected[$];
    logic signed [23:0] pt_x[1024];
    logic signed [23:0] pt_y[1024];
    logic signed [23:0] pt_z[1024];
    logic               wrap_on = 1'b0;
    logic [23:0]        ext_x = 24'hFFFFFF;
    logic [23:0]        ext_y = 24'hFFFFFF;
    logic [23:0]        ext_z = 24'hFFFFFF;
    int unsigned        written_idx[$];
    bit                 is_written[1024];
    bit                 calm = 1'b0;
    bit                 took = 1'b0;
    bit                 failed = 1'b0;
    int unsigned        n_pushed = 0;
    int unsigned        n_taken = 0;
    int unsigned        cycles = 0;
    int unsigned        hold_left = 0;
    int unsigned        rx_cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned axis_sq(logic signed [23:0] a, logic signed [23:0] b,
                                                logic [23:0] ext);
        longint d;
        longint w;
        d = longint'(a) - longint'(b);
        if (d < 0) d = -d;
        if (wrap_on) begin
            w = longint'({1'b0, ext}) - d;
            if (w < d) d = w;
        end
        return longint'(d * d);
    endfunction

    function automatic logic [24:0] pair_distance(int unsigned i, int unsigned j);
        longint unsigned s;
        longint unsigned r;
        if (i == j) return '0;
        s = axis_sq(pt_x[i], pt_x[j], ext_x) + axis_sq(pt_y[i], pt_y[j], ext_y)
            + axis_sq(pt_z[i], pt_z[j], ext_z);
        r = int_sqrt(s);
        if (r > 64'h1FFFFFF) r = 64'h1FFFFFF;
        return r[24:0];
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Input driver.
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || took)) begin
            if (op_queue.size() != 0 && (calm || $urandom_range(99) >= 17)) begin
                point_op_t it;
                it = op_queue.pop_front();
                s_opcode       <= it.op;
                s_first_index  <= it.fi;
                s_second_index <= it.si;
                s_coord_x      <= it.x;
                s_coord_y      <= it.y;
                s_coord_z      <= it.z;
                s_valid        <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver with one long hold-off to back the block up.
    always @(negedge aclk) begin
        rx_cycles <= rx_cycles + 1;
        if (rx_cycles == 2500) begin
            hold_left <= 400;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && (calm || $urandom_range(99) >= 17);
        end
    end

    // Transfer monitor and predictor.
    always @(posedge aclk) begin
        took <= s_valid && s_ready;
        if (s_valid && s_ready) begin
            n_taken <= n_taken + 1;
            if (opcode_t'(s_opcode) == OP_WRITE) begin
                pt_x[s_first_index] <= s_coord_x;
                pt_y[s_first_index] <= s_coord_y;
                pt_z[s_first_index] <= s_coord_z;
            end else begin
                dist_expected.insert(dist_expected.size(),
                    pair_distance(32'(s_first_index), 32'(s_second_index)));
            end
        end
        if (m_valid && m_ready) begin
            if (dist_expected.size() == 0) begin
                $error("distance: no result expected, got %0d", m_distance);
                failed <= 1'b1;
            end else begin
                logic [24:0] e;
                e = dist_expected.pop_front();
                if (m_distance !== e) begin
                    $error("distance: expected %0d, actual %0d", e, m_distance);
                    failed <= 1'b1;
                end
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_WRAP_MODE: wrap_on = val[0];
            CFG_EXTENT_X:  ext_x = val;
            CFG_EXTENT_Y:  ext_y = val;
            default:       ext_z = val;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_op(opcode_t op, int unsigned fi, int unsigned si,
                          logic [23:0] x, logic [23:0] y, logic [23:0] z);
        point_op_t it;
        it.op = op;
        it.fi = 10'(fi);
        it.si = 10'(si);
        it.x = x;
        it.y = y;
        it.z = z;
        if (op == OP_WRITE && !is_written[fi]) begin
            is_written[fi] = 1'b1;
            written_idx.insert(written_idx.size(), fi);
        end
        op_queue.insert(op_queue.size(), it);
        n_pushed++;
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(3))
            0: return 24'($urandom_range(1023) - 512);
            1: return $urandom_range(2) == 0 ? 24'h7FFFFF : 24'h800000;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_ops(int unsigned n);
        for (int k = 0; k < n; k++) begin
            if (written_idx.size() < 2 || $urandom_range(99) < 35) begin
                int unsigned fi;
                fi = ($urandom_range(1) == 0) ? $urandom_range(1023) : $urandom_range(31);
                add_op(OP_WRITE, fi, $urandom_range(1023), rand_coord(), rand_coord(),
                       rand_coord());
            end else begin
                int unsigned a;
                int unsigned b;
                a = written_idx[$urandom_range(written_idx.size() - 1)];
                b = ($urandom_range(9) == 0) ? a
                    : written_idx[$urandom_range(written_idx.size() - 1)];
                add_op(OP_QUERY, a, b, 24'($urandom), 24'($urandom), 24'($urandom));
            end
        end
    endtask

    task automatic drain();
        while (n_taken != n_pushed || dist_expected.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_reg(CFG_WRAP_MODE, 24'd0);
        write_reg(CFG_EXTENT_X, 24'hFFFFFF);
        write_reg(CFG_EXTENT_Y, 24'hFFFFFF);
        write_reg(CFG_EXTENT_Z, 24'hFFFFFF);
        add_op(OP_WRITE, 0, 1023, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        add_op(OP_WRITE, 1023, 0, 24'h800000, 24'h800000, 24'h800000);
        add_op(OP_WRITE, 512, 341, 24'h0, 24'h0, 24'h0);
        add_op(OP_WRITE, 1, 682, 24'h000100, 24'hFFFF00, 24'h000001);
        add_op(OP_QUERY, 0, 1023, 24'hFFFFFF, 24'h0, 24'hAAAAAA);
        add_op(OP_QUERY, 1023, 0, 24'h0, 24'hFFFFFF, 24'h555555);
        add_op(OP_QUERY, 512, 512, 24'h0, 24'h0, 24'h0);
        add_op(OP_QUERY, 0, 512, 24'h0, 24'h0, 24'h0);
        add_op(OP_QUERY, 1, 512, 24'h0, 24'h0, 24'h0);
        add_op(OP_QUERY, 1023, 1, 24'h0, 24'h0, 24'h0);
        add_op(OP_WRITE, 0, 0, 24'h000000, 24'h7FFFFF, 24'h800000);
        add_op(OP_QUERY, 0, 1, 24'h0, 24'h0, 24'h0);
        drain();

        write_reg(CFG_WRAP_MODE, 24'd1);
        add_op(OP_QUERY, 0, 1023, 24'h0, 24'h0, 24'h0);
        add_op(OP_QUERY, 1, 512, 24'h0, 24'h0, 24'h0);
        random_ops(200);
        drain();

        write_reg(CFG_EXTENT_X, 24'h0);
        write_reg(CFG_EXTENT_Y, 24'h0);
        write_reg(CFG_EXTENT_Z, 24'h0);
        add_op(OP_QUERY, 0, 1023, 24'h0, 24'h0, 24'h0);
        random_ops(200);
        drain();

        calm = 1'b1;
        write_reg(CFG_EXTENT_X, 24'($urandom));
        write_reg(CFG_EXTENT_Y, 24'($urandom));
        write_reg(CFG_EXTENT_Z, 24'($urandom));
        random_ops(250);
        drain();
        calm = 1'b0;

        write_reg(CFG_EXTENT_X, 24'($urandom_range(24'h1FFFF)));
        write_reg(CFG_EXTENT_Y, 24'($urandom_range(24'hFFFFFF, 24'h800000)));
        write_reg(CFG_EXTENT_Z, 24'($urandom_range(24'h3FF)));
        random_ops(300);
        drain();

        write_reg(CFG_WRAP_MODE, 24'd0);
        random_ops(300);
        drain();

        if (!failed) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== point_pair_distance_engine.f =====
sv/ppde_pkg.sv
sv/ppde_ram.sv
sv/point_pair_distance_engine.sv
dv/tb_top.sv
